// ===== rtl/jsu_pkg.sv =====
// Package for the string unescaper: transfer types, decoder modes, character
// constants and the UTF-8 encoding helpers. No dependencies.
package jsu_pkg;

  localparam logic [7:0] QuoteChar  = 8'd34;
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChLowerU   = 8'h75;
  localparam logic [7:0] ChLowerA   = 8'h61;
  localparam logic [7:0] ChLowerB   = 8'h62;
  localparam logic [7:0] ChLowerF   = 8'h66;
  localparam logic [7:0] ChLowerN   = 8'h6E;
  localparam logic [7:0] ChLowerR   = 8'h72;
  localparam logic [7:0] ChLowerT   = 8'h74;
  localparam logic [7:0] ChLowerV   = 8'h76;
  localparam logic [7:0] ChZero     = 8'h30;
  localparam logic [7:0] ChNine     = 8'h39;
  localparam logic [7:0] ChUpperA   = 8'h41;
  localparam logic [7:0] ChUpperF   = 8'h46;

  localparam logic [15:0] HighFirst = 16'hD800;
  localparam logic [15:0] HighLast  = 16'hDBFF;
  localparam logic [15:0] LowFirst  = 16'hDC00;
  localparam logic [15:0] LowLast   = 16'hDFFF;
  localparam logic [20:0] SuppBase  = 21'h10000;

  typedef enum logic [2:0] {
    MODE_TEXT    = 3'd0,
    MODE_ESC     = 3'd1,
    MODE_HEX1    = 3'd2,
    MODE_WANT_BS = 3'd3,
    MODE_WANT_U  = 3'd4,
    MODE_HEX2    = 3'd5
  } mode_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       string_end;
    logic       error_flag;
    logic       last;
  } out_t;

  // Up to four results from one item; n is the count (0..4).
  typedef struct packed {
    logic [2:0]     n;
    out_t [3:0]     res;
  } group_t;

  function automatic out_t byte_res(input logic [7:0] b);
    out_t r;
    r            = '0;
    r.out_byte   = b;
    r.byte_valid = 1'b1;
    return r;
  endfunction

  // {ok, value}
  function automatic logic [4:0] hex_val(input logic [7:0] b);
    logic [4:0] r;
    r = '0;
    if (b >= ChZero && b <= ChNine) begin
      r = {1'b1, 4'(b - ChZero)};
    end else if (b >= ChUpperA && b <= ChUpperF) begin
      r = {1'b1, 4'(b - ChUpperA + 8'd10)};
    end else if (b >= ChLowerA && b <= ChLowerF) begin
      r = {1'b1, 4'(b - ChLowerA + 8'd10)};
    end
    return r;
  endfunction

  function automatic logic [7:0] esc_map(input logic [7:0] b);
    logic [7:0] c;
    case (b)
      ChLowerA: c = 8'd7;
      ChLowerB: c = 8'd8;
      ChLowerF: c = 8'd12;
      ChLowerN: c = 8'd10;
      ChLowerR: c = 8'd13;
      ChLowerT: c = 8'd9;
      ChLowerV: c = 8'd11;
      default:  c = b;
    endcase
    return c;
  endfunction

  function automatic group_t utf8_encode(input logic [20:0] cp);
    group_t g;
    g = '0;
    if (cp <= 21'h7F) begin
      g.n      = 3'd1;
      g.res[0] = byte_res(cp[7:0]);
    end else if (cp <= 21'h7FF) begin
      g.n      = 3'd2;
      g.res[0] = byte_res({3'b110, cp[10:6]});
      g.res[1] = byte_res({2'b10, cp[5:0]});
    end else if (cp <= 21'hFFFF) begin
      g.n      = 3'd3;
      g.res[0] = byte_res({4'b1110, cp[15:12]});
      g.res[1] = byte_res({2'b10, cp[11:6]});
      g.res[2] = byte_res({2'b10, cp[5:0]});
    end else if (cp <= 21'h10FFFF) begin
      g.n      = 3'd4;
      g.res[0] = byte_res({5'b11110, cp[20:18]});
      g.res[1] = byte_res({2'b10, cp[17:12]});
      g.res[2] = byte_res({2'b10, cp[11:6]});
      g.res[3] = byte_res({2'b10, cp[5:0]});
    end
    return g;
  endfunction

endpackage

// ===== rtl/json_string_unescape_utf8.sv =====
// Top level of the JSON string body unescaper (\u escapes, surrogate pairs to UTF-8).
// Depends on jsu_pkg, jsu_decode and jsu_outq.
//
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+----------------------------
//  in      | input     | in_valid_i/in_ready_o| jsu_pkg::in_t  (byte, eoi)
//  out     | output    | out_valid_o/out_ready_i | jsu_pkg::out_t (byte, flags)
//
// One source byte per cycle while the result register can take each byte's results;
// the first result of a byte passes the input register, then the result register.
// An item giving k results occupies the result register until all k are taken (k up to
// four for a supplementary code point); items giving no result never load it.
// While the result register is stalled, the input register takes one byte and
// holds it if that byte gives results; bytes giving none still pass each cycle.
// Reset (rst_ni low, asynchronous) empties both registers and puts the
// decoder in plain text mode.
module json_string_unescape_utf8 (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  jsu_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output jsu_pkg::out_t out_data_o
);

  // Input register: one accepted byte waiting for the decoder.
  logic            inv_q;
  jsu_pkg::in_t    in_q;

  jsu_pkg::group_t grp;
  logic            free;
  logic            commit;

  // An item commits (state advances, results load) once the result register
  // can take its group; an item with no results commits at once.
  assign commit     = inv_q && ((grp.n == 3'd0) || free);
  assign in_ready_o = !inv_q || commit;

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      inv_q <= 1'b1;
    end else if (commit) begin
      inv_q <= 1'b0;
    end
  end

  jsu_decode u_decode (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (in_q),
    .commit_i (commit),
    .grp_o    (grp)
  );

  // Result register and serialiser: one result per output transfer.
  jsu_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (commit && (grp.n != 3'd0)),
    .grp_i       (grp),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== rtl/jsu_decode.sv =====
// Escape decoder: mode/hex/surrogate state and the result group for one item.
// Depends on jsu_pkg.
module jsu_decode (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  jsu_pkg::in_t    item_i,
  input  logic            commit_i,
  output jsu_pkg::group_t grp_o
);

  jsu_pkg::mode_e  mode_q, mode_d;
  logic [1:0]      cnt_q, cnt_d;
  logic [15:0]     acc_q, acc_d;
  logic [15:0]     hi_q, hi_d;

  logic [7:0]      b;
  logic [4:0]      hx;
  logic [15:0]     code;
  logic            do_plain;
  jsu_pkg::group_t grp;

  always_comb begin
    b        = item_i.in_byte;
    hx       = jsu_pkg::hex_val(b);
    code     = {acc_q[11:0], hx[3:0]};
    mode_d   = mode_q;
    cnt_d    = cnt_q;
    acc_d    = acc_q;
    hi_d     = hi_q;
    do_plain = 1'b0;
    grp      = '0;

    if (item_i.end_of_input) begin
      mode_d               = jsu_pkg::MODE_TEXT;
      cnt_d                = '0;
      acc_d                = '0;
      hi_d                 = '0;
      grp.n                = 3'd1;
      grp.res[0].error_flag = 1'b1;
    end else begin
      case (mode_q)
        jsu_pkg::MODE_ESC: begin
          mode_d = jsu_pkg::MODE_TEXT;
          if (b == jsu_pkg::ChLowerU) begin
            mode_d = jsu_pkg::MODE_HEX1;
            cnt_d  = '0;
            acc_d  = '0;
          end else begin
            grp.n      = 3'd1;
            grp.res[0] = jsu_pkg::byte_res(jsu_pkg::esc_map(b));
          end
        end
        jsu_pkg::MODE_HEX1, jsu_pkg::MODE_HEX2: begin
          if (!hx[4]) begin
            do_plain = 1'b1;
          end else if (cnt_q != 2'd3) begin
            acc_d = code;
            cnt_d = cnt_q + 2'd1;
          end else begin
            cnt_d  = '0;
            acc_d  = '0;
            mode_d = jsu_pkg::MODE_TEXT;
            if (mode_q == jsu_pkg::MODE_HEX1) begin
              if (code == 16'd0 ||
                  (code >= jsu_pkg::LowFirst && code <= jsu_pkg::LowLast)) begin
                grp = '0;
              end else if (code >= jsu_pkg::HighFirst && code <= jsu_pkg::HighLast) begin
                hi_d   = code;
                mode_d = jsu_pkg::MODE_WANT_BS;
              end else begin
                grp = jsu_pkg::utf8_encode({5'd0, code});
              end
            end else if (code >= jsu_pkg::LowFirst && code <= jsu_pkg::LowLast) begin
              // pair: 0x10000 + (high & 0x3FF) * 0x400 + (low & 0x3FF)
              grp = jsu_pkg::utf8_encode(jsu_pkg::SuppBase + {1'b0, hi_q[9:0], code[9:0]});
            end
          end
        end
        jsu_pkg::MODE_WANT_BS: begin
          if (b == jsu_pkg::ChBackslash) begin
            mode_d = jsu_pkg::MODE_WANT_U;
          end else begin
            do_plain = 1'b1;
          end
        end
        jsu_pkg::MODE_WANT_U: begin
          if (b == jsu_pkg::ChLowerU) begin
            mode_d = jsu_pkg::MODE_HEX2;
            cnt_d  = '0;
            acc_d  = '0;
          end else begin
            do_plain = 1'b1;
          end
        end
        default: begin
          do_plain = 1'b1;
        end
      endcase

      if (do_plain) begin
        mode_d = jsu_pkg::MODE_TEXT;
        if (b == jsu_pkg::QuoteChar) begin
          grp.n                 = 3'd1;
          grp.res[0].string_end = 1'b1;
        end else if (b == jsu_pkg::ChBackslash) begin
          mode_d = jsu_pkg::MODE_ESC;
        end else begin
          grp.n      = 3'd1;
          grp.res[0] = jsu_pkg::byte_res(b);
        end
      end
    end
  end

  assign grp_o = grp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= jsu_pkg::MODE_TEXT;
      cnt_q  <= '0;
      acc_q  <= '0;
      hi_q   <= '0;
    end else if (commit_i) begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
      acc_q  <= acc_d;
      hi_q   <= hi_d;
    end
  end

endmodule

// ===== rtl/jsu_outq.sv =====
// Result register: holds one group of up to four results and hands them out
// one per transfer. Depends on jsu_pkg.
module jsu_outq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  jsu_pkg::group_t grp_i,
  output logic            free_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output jsu_pkg::out_t   out_data_o
);

  jsu_pkg::group_t grp_q;
  logic [2:0]      n_q;
  logic [1:0]      idx_q;
  logic [1:0]      last_idx;
  logic            is_last;

  assign last_idx    = 2'(n_q - 3'd1);
  assign is_last     = (idx_q == last_idx);
  assign out_valid_o = (n_q != 3'd0);
  assign free_o      = !out_valid_o || (out_ready_i && is_last);

  always_comb begin
    out_data_o      = grp_q.res[idx_q];
    out_data_o.last = is_last;
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      grp_q <= grp_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q   <= '0;
      idx_q <= '0;
    end else if (load_i) begin
      n_q   <= grp_i.n;
      idx_q <= '0;
    end else if (out_valid_o && out_ready_i) begin
      if (is_last) begin
        n_q <= '0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

endmodule

// ===== rtl/jsu_check.sv =====
// Port checker for the string unescaper, bound to the top level.
// Depends on jsu_pkg and json_string_unescape_utf8.
module jsu_check (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input jsu_pkg::out_t out_data_o
);

  // Nothing leaves the block while reset is held.
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("output valid during reset");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // Error and string end results stand alone and close their item's group.
  a_flag_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.error_flag || out_data_o.string_end) |->
      out_data_o.last && !out_data_o.byte_valid &&
      !(out_data_o.error_flag && out_data_o.string_end))
    else $error("flag result not alone");

  // Non-byte results carry a zero byte.
  a_zero_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.byte_valid |-> out_data_o.out_byte == 8'd0)
    else $error("non-byte result has data");

  // Inside a UTF-8 burst (no last), the next byte taken is a continuation byte.
  a_cont_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_data_o.last |=>
      out_valid_o && out_data_o.byte_valid && (out_data_o.out_byte[7:6] == 2'b10))
    else $error("broken UTF-8 burst");

endmodule

bind json_string_unescape_utf8 jsu_check u_check (.*);
